@@ sv/lcd_scanline_timing_counter_assert.svh @@
// Assertion macros for the scanline timing counter.
`ifndef LCD_SCANLINE_TIMING_COUNTER_ASSERT_SVH
`define LCD_SCANLINE_TIMING_COUNTER_ASSERT_SVH

`ifndef SYNTH

// Checks a condition at every clock edge outside reset.
`define LCDST_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LCDST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define LCDST_ASSERT(lbl, cond, msg)
`define LCDST_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

@@ sv/lcdst_pkg.sv @@
// Types and constants shared by the scanline timing counter modules.
package lcdst_pkg;

  localparam logic [15:0] LyAddr       = 16'hFF44;
  localparam logic [7:0]  VblankMask   = 8'd144;
  localparam logic [7:0]  LastLineMask = 8'd153;
  localparam logic [6:0]  DotEndMask   = 7'd113;
  localparam logic [6:0]  DotReset     = 7'd99;

  localparam logic [2:0] PhaseB = 3'd1;
  localparam logic [2:0] PhaseD = 3'd3;
  localparam logic [2:0] PhaseF = 3'd5;
  localparam logic [2:0] PhaseH = 3'd7;

  typedef struct packed {
    logic [2:0]  phase;
    logic        lcd_enable;
    logic        read_request;
    logic [15:0] read_address;
  } item_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  read_data;
    logic [6:0]  dot_count;
    logic [7:0]  line_count;
    logic        vblank;
    logic        vsync_n;
    logic        line_trigger;
  } result_t;

  typedef struct packed {
    logic [6:0] dot;
    logic [7:0] line;
    logic       line_done;
    logic       line_start;
    logic       video_end1;
    logic       video_end2;
    logic       last_line;
    logic       vsync;
    logic       vblank;
  } timing_t;

  localparam timing_t TimingReset = '{
    dot:        DotReset,
    line:       8'd0,
    line_done:  1'b0,
    line_start: 1'b0,
    video_end1: 1'b0,
    video_end2: 1'b0,
    last_line:  1'b1,
    vsync:      1'b0,
    vblank:     1'b0
  };

endpackage

@@ sv/lcdst_step.sv @@
// Next-state and result logic for one phase beat of the scanline timing.
module lcdst_step (
  input  lcdst_pkg::item_t   item_i,
  input  lcdst_pkg::timing_t state_i,
  output lcdst_pkg::timing_t state_o,
  output lcdst_pkg::result_t result_o
);
  import lcdst_pkg::*;

  logic ph_b, ph_d, ph_f, ph_h;
  logic vblank_now, vid_line, not_line0, is_last, dot_end, hit;
  timing_t nx;

  assign ph_b = item_i.phase == PhaseB;
  assign ph_d = item_i.phase == PhaseD;
  assign ph_f = item_i.phase == PhaseF;
  assign ph_h = item_i.phase == PhaseH;

  assign vblank_now = (state_i.line & VblankMask) == VblankMask;
  assign vid_line   = state_i.line_done && !vblank_now;
  assign not_line0  = state_i.line != 8'd0;
  assign is_last    = (state_i.line & LastLineMask) == LastLineMask;
  assign dot_end    = (state_i.dot & DotEndMask) == DotEndMask;
  assign hit        = item_i.read_request && (item_i.read_address == LyAddr);

  always_comb begin
    nx = state_i;
    if (ph_b) begin
      nx.dot = state_i.dot + 7'd1;
      // Line flags are captured once, on the first B phase after a line end.
      if (state_i.line_done && !state_i.line_start) begin
        nx.last_line = is_last;
        nx.vsync     = not_line0;
        nx.vblank    = vblank_now;
      end
      nx.line_start = state_i.line_done;
    end
    if (ph_f) begin
      if (dot_end && !state_i.line_done) begin
        nx.line = state_i.line + 8'd1;
      end
      nx.line_done = dot_end;
    end
    if (ph_b || ph_f) begin
      nx.video_end1 = vid_line;
    end
    if (ph_d || ph_h) begin
      nx.video_end2 = state_i.video_end1;
    end
    // These clears use the flags as they stand after this beat's updates.
    if (nx.line_done) begin
      nx.dot = 7'd0;
    end
    if (nx.last_line) begin
      nx.line = 8'd0;
    end
    if (!item_i.lcd_enable) begin
      nx.dot        = 7'd0;
      nx.line       = 8'd0;
      nx.line_done  = 1'b0;
      nx.line_start = 1'b0;
      nx.last_line  = 1'b0;
      nx.vsync      = 1'b0;
      nx.vblank     = 1'b0;
    end
  end

  assign state_o = nx;

  always_comb begin
    result_o.read_valid   = hit;
    result_o.read_data    = hit ? state_i.line : 8'd0;
    result_o.dot_count    = nx.dot;
    result_o.line_count   = nx.line;
    result_o.vblank       = nx.vblank;
    result_o.vsync_n      = nx.vsync;
    result_o.line_trigger = (nx.video_end1 && !nx.video_end2) || !item_i.lcd_enable;
  end

endmodule

@@ sv/lcd_scanline_timing_counter.sv @@
// Top level of the scanline timing counter: input register, timing state, result register.
// One phase beat can be accepted every clock cycle while in_stall_o is low; it passes from
// the input register through the step logic into the result register. The rate is one beat
// per cycle when not stalled, set by the combinational step logic between the two
// registers, which updates the dot counter, line counter and flags in the same cycle. The
// block holds at most two beats, so the input stalls only when a result is held off and the
// input register is also occupied. A read of 0xFF44 returns the line count from before the
// beat. Dropping lcd_enable forces line_trigger high, clearing all state but video_end1/2.
module lcd_scanline_timing_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  phase_i,
  input  logic        lcd_enable_i,
  input  logic        read_request_i,
  input  logic [15:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  output logic [6:0]  dot_count_o,
  output logic [7:0]  line_count_o,
  output logic        vblank_o,
  output logic        vsync_n_o,
  output logic        line_trigger_o
);
  import lcdst_pkg::*;

  `include "lcd_scanline_timing_counter_assert.svh"

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  timing_t state_q, state_d;
  result_t result_q, result_d;
  logic    out_valid_q, out_valid_d;
  logic    advance, in_accept;

  // A beat moves into the result register when that register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  lcdst_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= TimingReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{phase: phase_i, lcd_enable: lcd_enable_i,
                  read_request: read_request_i, read_address: read_address_i};
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_valid_o   = result_q.read_valid;
  assign read_data_o    = result_q.read_data;
  assign dot_count_o    = result_q.dot_count;
  assign line_count_o   = result_q.line_count;
  assign vblank_o       = result_q.vblank;
  assign vsync_n_o      = result_q.vsync_n;
  assign line_trigger_o = result_q.line_trigger;

  `LCDST_ASSERT_NEXT(a_state_holds, !advance, $stable(state_q),
                     "timing state changed without a beat")
  `LCDST_ASSERT_NEXT(a_result_follows, advance, out_valid_q, "beat advanced but no result shown")
  `LCDST_ASSERT_NEXT(a_disable_clears, advance && !item_q.lcd_enable,
                     state_q.dot == 7'd0 && state_q.line == 8'd0 && !state_q.vblank,
                     "display off did not clear counters")
  `LCDST_ASSERT_NEXT(a_disable_trigger, advance && !item_q.lcd_enable, result_q.line_trigger,
                     "display off did not force line trigger")

endmodule
